[hdl/assert_macros.svh]
// assertion macros included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// implication checked at the next edge
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`endif

[hdl/mlpfwd_pkg.sv]
// types, constants and functions of the perceptron block
package mlpfwd_pkg;
   localparam int MAX_INPUTS  = 32;
   localparam int MAX_HIDDEN  = 32;
   localparam int MAX_WEIGHTS = 4096;
   localparam int WADDR_W     = $clog2(MAX_WEIGHTS);
   localparam int FIDX_W      = $clog2(MAX_INPUTS);
   localparam int HIDX_W      = $clog2(MAX_HIDDEN);
   localparam int CELLS       = (MAX_INPUTS > MAX_HIDDEN) ? MAX_INPUTS : MAX_HIDDEN;
   localparam int CIDX_W      = $clog2(CELLS);
   localparam int ACC_W       = 56;
   localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      FUNC_WEIGHT  = 2'd0,
      FUNC_FEATURE = 2'd1,
      FUNC_CLEAR   = 2'd2,
      FUNC_NONE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      CSR_LAYERS  = 2'd0,
      CSR_INPUTS  = 2'd1,
      CSR_HIDDEN1 = 2'd2,
      CSR_HIDDEN2 = 2'd3
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADDR,
      ST_MAC,
      ST_DRAIN,
      ST_REDUCE,
      ST_ACT,
      ST_ERR,
      ST_OUT
   } state_type;

   // one product step handed to the cell row
   typedef struct packed {
      logic                    load;
      logic                    shift;
      logic [CIDX_W-1:0]       wr_idx;
      logic [15:0]             wr_data;
   } row_ctl_type;

   function automatic logic [15:0] sigmoid(input logic signed [15:0] x);
      logic [16:0] z;
      logic [16:0] y;
      begin
         z = x[15] ? 17'(-$signed({x[15], x})) : {1'b0, x};
         if (z >= 17'd20480)     y = 17'd65536;
         else if (z >= 17'd9728) y = (z >> 1) + 17'd55296;
         else if (z >= 17'd4096) y = (z << 1) + 17'd40960;
         else                    y = (z << 2) + 17'd32768;
         if (x[15]) y = 17'd65536 - y;
         sigmoid = (y > 17'd65535) ? 16'hFFFF : y[15:0];
      end
   endfunction

   function automatic logic [WADDR_W:0] clamp_cnt(input logic [5:0] v, input int hi);
      begin
         if (v == 6'd0)          clamp_cnt = (WADDR_W+1)'(1);
         else if (int'(v) > hi)  clamp_cnt = (WADDR_W+1)'(hi);
         else                    clamp_cnt = (WADDR_W+1)'(v);
      end
   endfunction
endpackage

[hdl/mlp_forward_with_sq_error.sv]
// top level: perceptron forward pass with squared error accounting
// the multiply-accumulate unit takes one product per cycle while it steps through a node's columns
// throughput: one sample at a time, set by the single multiply-accumulate unit
// input is held off while a pass runs; a result waiting in the output register
//   holds the next pass at its end
// reset clears error sum, feature count and sequencer, and sets config to defaults
`include "assert_macros.svh"
module mlp_forward_with_sq_error (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[1:0], weight_index[13:2], weight_value[29:14], feature_value[45:30],
   // zero fill[47:46]
   input  logic [47:0] req_tdata,
   // last_feature[0], target_class[1]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // prediction[15:0], sample_error[31:16], error_sum[71:32]
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);
   import mlpfwd_pkg::*;

   logic [1:0] layers_ff, layers_in;
   logic [5:0] ni_ff, ni_in, n1_ff, n1_in, n2_ff, n2_in;
   logic [FIDX_W:0] fcnt_ff, fcnt_in;
   logic [39:0] sum_ff, sum_in;
   logic        target_ff, target_in;
   state_type   state_ff, state_in;
   logic [1:0]  layer_ff, layer_in;       // 0 layer1, 1 layer2, 2 output
   logic [HIDX_W:0] node_ff, node_in;
   logic [WADDR_W:0] col_ff, col_in;
   logic [WADDR_W+1:0] base_ff, base_in;
   logic        signed [ACC_W-1:0] acc_ff, acc_in;
   logic        signed [15:0] red_ff, red_in;
   logic [15:0] pred_ff, pred_in;
   logic        rv_ff, rv_in;
   logic [71:0] rdata_ff, rdata_in;
   logic [15:0] err_ff, err_in;

   logic [15:0] wmem [MAX_WEIGHTS];
   logic [15:0] hmem [2][MAX_HIDDEN];
   logic [15:0] wq_ff, hq_ff;
   logic        mv_ff, mv_in;
   logic signed [45:0] prod_ff;
   logic        pv_ff;

   logic [1:0]  func;
   logic [WADDR_W-1:0] widx;
   logic [15:0] wval, fval;
   logic        acc_req, fire;
   logic [WADDR_W:0] ni_c, n1_c, n2_c, ncols, nnodes;
   logic        two;
   row_ctl_type ctl;
   logic [16:0] head;
   logic [WADDR_W+1:0] raddr;
   logic [HIDX_W-1:0] hwr_idx;
   logic        hwr;
   logic        signed [ACC_W-1:0] shifted;
   logic [16:0] diff;
   logic [33:0] sq;
   logic [40:0] nsum;

   assign func = req_tdata[1:0];
   assign widx = req_tdata[2 +: WADDR_W];
   assign wval = req_tdata[29:14];
   assign fval = req_tdata[45:30];
   assign req_tready = (state_ff == ST_IDLE);
   assign acc_req = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign ni_c = clamp_cnt(ni_ff, MAX_INPUTS);
   assign n1_c = clamp_cnt(n1_ff, MAX_HIDDEN);
   assign n2_c = clamp_cnt(n2_ff, MAX_HIDDEN);
   assign two = layers_ff[1];
   assign ncols = (layer_ff == 2'd0) ? ni_c : ((layer_ff == 2'd1 || !two) ? n1_c : n2_c);
   assign nnodes = (layer_ff == 2'd0) ? n1_c : ((layer_ff == 2'd1) ? n2_c : (WADDR_W+1)'(1));
   assign raddr = base_ff + (WADDR_W+2)'(col_ff);
   assign fire = acc_req && func == FUNC_FEATURE && req_tuser[0];

   // column zero of the row holds nothing; cells feed columns one upward
   always_comb begin
      ctl = '0;
      ctl.wr_idx = CIDX_W'(fcnt_ff);
      ctl.wr_data = fval;
      if (acc_req && func == FUNC_FEATURE && fcnt_ff < (FIDX_W+1)'(MAX_INPUTS))
         ctl.load = 1'b1;
      if (state_ff == ST_MAC && col_ff > (WADDR_W+1)'(1)) ctl.shift = 1'b1;
   end

   mlpfwd_row u_row (
      .clock       (clock),
      .ctl         (ctl),
      .signed_mode (1'b1),
      .head        (head)
   );

   always_comb begin
      layers_in = layers_ff; ni_in = ni_ff; n1_in = n1_ff; n2_in = n2_ff;
      if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_LAYERS:  layers_in = csr_data[1:0];
            CSR_INPUTS:  ni_in = csr_data;
            CSR_HIDDEN1: n1_in = csr_data;
            CSR_HIDDEN2: n2_in = csr_data;
            default:     ;
         endcase
      end
   end

   assign shifted = (layer_ff == 2'd0) ? (acc_ff >>> 12) : (acc_ff >>> 16);
   assign diff = target_ff ? (17'd65536 - {1'b0, pred_ff}) : {1'b0, pred_ff};
   assign sq = 34'(diff) * 34'(diff);
   assign nsum = {1'b0, sum_ff} + 41'(err_ff);

   always_comb begin
      state_in = state_ff; layer_in = layer_ff; node_in = node_ff; col_in = col_ff;
      base_in = base_ff; acc_in = acc_ff; red_in = red_ff; pred_in = pred_ff;
      fcnt_in = fcnt_ff; sum_in = sum_ff; target_in = target_ff;
      rv_in = rv_ff; rdata_in = rdata_ff; err_in = err_ff; mv_in = 1'b0;
      hwr = 1'b0; hwr_idx = HIDX_W'(node_ff);
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      if (pv_ff) acc_in = acc_ff + ACC_W'(prod_ff);
      case (state_ff)
         ST_IDLE: begin
            if (acc_req) begin
               if (func == FUNC_CLEAR) sum_in = '0;
               if (func == FUNC_FEATURE) begin
                  if (fcnt_ff < (FIDX_W+1)'(MAX_INPUTS)) fcnt_in = fcnt_ff + 1'b1;
                  if (req_tuser[0]) begin
                     fcnt_in = '0;
                     target_in = req_tuser[1];
                     layer_in = 2'd0; node_in = '0; base_in = '0;
                     state_in = ST_ADDR;
                  end
               end
            end
         end
         ST_ADDR: begin
            col_in = '0; acc_in = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            mv_in = 1'b1;
            if (col_ff == ncols) state_in = ST_DRAIN;
            else col_in = col_ff + 1'b1;
         end
         ST_DRAIN: begin
            if (!mv_ff && !pv_ff) state_in = ST_REDUCE;
         end
         ST_REDUCE: begin
            if (shifted > ACC_W'(32767)) red_in = 16'sd32767;
            else if (shifted < -ACC_W'(32768)) red_in = -16'sd32768;
            else red_in = shifted[15:0];
            state_in = ST_ACT;
         end
         ST_ACT: begin
            base_in = base_ff + (WADDR_W+2)'(ncols) + 1'b1;
            if (layer_ff == 2'd2) begin
               pred_in = sigmoid(red_ff);
               state_in = ST_ERR;
            end else begin
               hwr = 1'b1;
               state_in = ST_ADDR;
               if (node_ff + 1'b1 == (HIDX_W+1)'(nnodes)) begin
                  node_in = '0;
                  layer_in = (layer_ff == 2'd0 && two) ? 2'd1 : 2'd2;
               end else node_in = node_ff + 1'b1;
            end
         end
         ST_ERR: begin
            err_in = (sq[33:16] > 18'd65535) ? 16'hFFFF : sq[31:16];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rv_ff || rsp_tready) begin
               sum_in = nsum[40] ? SUM_MAX : nsum[39:0];
               rdata_in = {(nsum[40] ? SUM_MAX : nsum[39:0]), err_ff, pred_ff};
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // later layers read their operands from hidden memory instead of the row
   always_ff @(posedge clock) begin
      if (acc_req && func == FUNC_WEIGHT) wmem[widx] <= wval;
      wq_ff <= wmem[raddr[WADDR_W-1:0]];
      if (hwr) hmem[layer_ff[0]][hwr_idx] <= sigmoid(red_ff);
      hq_ff <= hmem[(layer_ff == 2'd2) ? two : 1'b0][HIDX_W'(col_ff - 1'b1)];
   end

   logic [16:0] opnd;
   logic        first_ff;
   assign opnd = (layer_ff == 2'd0) ? head : {1'b0, hq_ff};
   always_ff @(posedge clock) begin
      first_ff <= (state_ff == ST_MAC) && col_ff == '0;
      pv_ff <= mv_ff;
      if (first_ff)
         prod_ff <= (layer_ff == 2'd0) ? 46'($signed(wq_ff)) <<< 12
                                       : 46'($signed(wq_ff)) <<< 28;
      else
         prod_ff <= 46'(34'($signed(wq_ff)) * 34'($signed(opnd)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layers_ff <= 2'd1; ni_ff <= 6'd8; n1_ff <= 6'd8; n2_ff <= 6'd8;
         fcnt_ff <= '0; sum_ff <= '0; state_ff <= ST_IDLE; rv_ff <= 1'b0;
         mv_ff <= 1'b0; layer_ff <= '0; node_ff <= '0;
      end else begin
         layers_ff <= layers_in; ni_ff <= ni_in; n1_ff <= n1_in; n2_ff <= n2_in;
         fcnt_ff <= fcnt_in; sum_ff <= sum_in; state_ff <= state_in; rv_ff <= rv_in;
         mv_ff <= mv_in; layer_ff <= layer_in; node_ff <= node_in;
      end
      col_ff <= col_in; base_ff <= base_in; acc_ff <= acc_in; red_ff <= red_in;
      pred_ff <= pred_in; target_ff <= target_in; rdata_ff <= rdata_in; err_ff <= err_in;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = rdata_ff;

   `ASSERT_CLK(a_no_accept_busy, !(req_tready && state_ff != ST_IDLE), "accept while busy")
   `ASSERT_NEXT(a_fire_starts, fire, state_ff == ST_ADDR, "pass did not start")
   `ASSERT_NEXT(a_out_valid, state_ff == ST_OUT, rsp_tvalid, "result lost")
   `ASSERT_CLK(a_fcnt_range, fcnt_ff <= (FIDX_W+1)'(MAX_INPUTS), "feature count overflow")
endmodule

[hdl/mlpfwd_cell.sv]
// one cell of the operand row: holds a value and shifts it toward cell zero
module mlpfwd_cell (
   input  logic        clock,
   input  logic        load,
   input  logic        shift,
   input  logic        sel,
   input  logic [16:0] wr_data,
   input  logic [16:0] from_next,
   output logic [16:0] value
);
   logic [16:0] hold_ff, hold_in;
   logic [16:0] live_ff, live_in;

   always_comb begin
      hold_in = (load && sel) ? wr_data : hold_ff;
      live_in = live_ff;
      if (shift) live_in = from_next;
      else if (!load) live_in = hold_ff;
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      live_ff <= live_in;
   end

   assign value = live_ff;
endmodule

[hdl/mlpfwd_row.sv]
// row of operand cells; cell zero feeds the multiplier
module mlpfwd_row (
   input  logic                   clock,
   input  mlpfwd_pkg::row_ctl_type ctl,
   input  logic                   signed_mode,
   output logic [16:0]            head
);
   import mlpfwd_pkg::*;
   logic [16:0] val [CELLS];
   logic [16:0] wdata;

   assign wdata = signed_mode ? {ctl.wr_data[15], ctl.wr_data} : {1'b0, ctl.wr_data};

   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic [16:0] nxt;
      if (i == CELLS - 1) begin : g_end
         assign nxt = 17'd0;
      end else begin : g_mid
         assign nxt = val[i+1];
      end
      mlpfwd_cell u_cell (
         .clock     (clock),
         .load      (ctl.load),
         .shift     (ctl.shift),
         .sel       (ctl.wr_idx == CIDX_W'(i)),
         .wr_data   (wdata),
         .from_next (nxt),
         .value     (val[i])
      );
   end

   assign head = val[0];
endmodule
